### hw/rtl/vae_pkg.sv
`default_nettype none
package vae_pkg;

	localparam int unsigned IN_W = 24;
	localparam int unsigned THR_W = 10;
	localparam int unsigned AZ_W = 17;
	localparam int unsigned EL_W = 16;
	localparam int unsigned GUARD_BITS = 12;
	localparam int unsigned DP_W = 40;
	localparam int unsigned ANG_W = 26;
	localparam int unsigned OUT_PRE_W = 19;
	localparam int unsigned IDX_W = 5;
	localparam int unsigned TABLE_LEN = 24;
	localparam int unsigned CORDIC_STAGES = 16;
	localparam int unsigned NUM_CELLS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

	localparam logic [THR_W-1:0] THR_RESET = 10'd1;
	localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
	localparam logic signed [ANG_W-1:0] DEG90_Q16 = 26'sd5898240;
	localparam logic signed [OUT_PRE_W-1:0] AZ_LIMIT = 19'sd46080;
	localparam logic signed [OUT_PRE_W-1:0] EL_LIMIT = 19'sd23040;

	localparam logic signed [ANG_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
		26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
		26'sd917, 26'sd458, 26'sd229, 26'sd115,
		26'sd57, 26'sd29, 26'sd14, 26'sd7,
		26'sd4, 26'sd2, 26'sd1, 26'sd0
	};

	typedef struct packed {
		logic signed [DP_W-1:0] x;
		logic signed [DP_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
		logic signed [IN_W-1:0] z;
		logic signed [AZ_W-1:0] az;
		logic az_zero;
		logic z_small;
		logic el_zero;
	} vae_word_t;

	function automatic logic signed [OUT_PRE_W-1:0] round_sat(
		input logic signed [ANG_W-1:0] acc,
		input logic signed [OUT_PRE_W-1:0] lim
	);
		logic signed [ANG_W:0] sum;
		logic signed [OUT_PRE_W-1:0] v;
		sum = (ANG_W+1)'(acc) + 27'sd128;
		v = $signed(sum[ANG_W:8]);
		if (v > lim) begin
			v = lim;
		end else if (v < -lim) begin
			v = -lim;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/vae_in_if.sv
`default_nettype none
interface vae_in_if;
	import vae_pkg::*;

	logic valid;
	logic ready;
	logic signed [IN_W-1:0] vec_x;
	logic signed [IN_W-1:0] vec_y;
	logic signed [IN_W-1:0] vec_z;

	modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface
`default_nettype wire

### hw/rtl/vae_out_if.sv
`default_nettype none
interface vae_out_if;
	import vae_pkg::*;

	logic valid;
	logic ready;
	logic signed [AZ_W-1:0] azimuth_deg;
	logic signed [EL_W-1:0] elevation_deg;

	modport source (output valid, output azimuth_deg, output elevation_deg, input ready);
	modport sink (input valid, input azimuth_deg, input elevation_deg, output ready);
endinterface
`default_nettype wire

### hw/rtl/vector_azimuth_elevation_top.sv
`default_nettype none
// From an accepted word to its result word, the pipeline is one input stage, a row of
// azimuth cells, two multiplier stages for the inverse gain, a row of elevation cells
// and the output register.
// Throughput is one word per cycle unless the output stalls, with one cell per CORDIC stage.
// Reset clears every stage valid bit and sets the dead-zone threshold to one.
module vector_azimuth_elevation_top (
	input wire logic clk,
	input wire logic arst_n,
	vae_in_if.sink vec_in,
	vae_out_if.source ang_out,
	input wire logic cfg_we,
	input wire logic [vae_pkg::THR_W-1:0] cfg_wdata
);
	import vae_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic v_s0;
	logic take_s0;
	vae_word_t word_s0;
	vae_word_t front_d;
	logic signed [DP_W-1:0] xs;
	logic signed [DP_W-1:0] ys;
	logic [IN_W-1:0] abs_x;
	logic [IN_W-1:0] abs_y;
	logic [IN_W-1:0] abs_z;

	logic az_v [NUM_CELLS+1];
	logic az_t [NUM_CELLS+1];
	vae_word_t az_w [NUM_CELLS+1];
	logic el_v [NUM_CELLS+1];
	logic el_t [NUM_CELLS+1];
	vae_word_t el_w [NUM_CELLS+1];

	logic vo_q;
	logic take_o;
	logic signed [AZ_W-1:0] az_q;
	logic signed [EL_W-1:0] el_q;
	logic signed [OUT_PRE_W-1:0] el_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign xs = {{(DP_W-IN_W-GUARD_BITS){vec_in.vec_x[IN_W-1]}}, vec_in.vec_x,
		{GUARD_BITS{1'b0}}};
	assign ys = {{(DP_W-IN_W-GUARD_BITS){vec_in.vec_y[IN_W-1]}}, vec_in.vec_y,
		{GUARD_BITS{1'b0}}};
	assign abs_x = vec_in.vec_x[IN_W-1] ? IN_W'(-vec_in.vec_x) : IN_W'(vec_in.vec_x);
	assign abs_y = vec_in.vec_y[IN_W-1] ? IN_W'(-vec_in.vec_y) : IN_W'(vec_in.vec_y);
	assign abs_z = vec_in.vec_z[IN_W-1] ? IN_W'(-vec_in.vec_z) : IN_W'(vec_in.vec_z);

	always_comb begin
		front_d.x = xs;
		front_d.y = ys;
		front_d.ang = '0;
		if (vec_in.vec_x[IN_W-1]) begin
			if (!vec_in.vec_y[IN_W-1]) begin
				front_d.x = ys;
				front_d.y = -xs;
				front_d.ang = DEG90_Q16;
			end else begin
				front_d.x = -ys;
				front_d.y = xs;
				front_d.ang = -DEG90_Q16;
			end
		end
		front_d.z = vec_in.vec_z;
		front_d.az = '0;
		front_d.az_zero = (abs_x < IN_W'(thr_q)) && (abs_y < IN_W'(thr_q));
		front_d.z_small = abs_z < IN_W'(thr_q);
		front_d.el_zero = 1'b0;
	end

	assign take_s0 = !v_s0 || az_t[0];
	assign vec_in.ready = take_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (take_s0) begin
			v_s0 <= vec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s0 && vec_in.valid) begin
			word_s0 <= front_d;
		end
	end

	assign az_v[0] = v_s0;
	assign az_w[0] = word_s0;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_az
		vae_cordic_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.stage_idx(IDX_W'(g)),
			.in_vld(az_v[g]),
			.in_word(az_w[g]),
			.in_take(az_t[g]),
			.out_vld(az_v[g+1]),
			.out_word(az_w[g+1]),
			.out_take(az_t[g+1])
		);
	end

	vae_gain_mult u_gain (
		.clk(clk),
		.arst_n(arst_n),
		.thr(thr_q),
		.in_vld(az_v[NUM_CELLS]),
		.in_word(az_w[NUM_CELLS]),
		.in_take(az_t[NUM_CELLS]),
		.out_vld(el_v[0]),
		.out_word(el_w[0]),
		.out_take(el_t[0])
	);

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_el
		vae_cordic_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.stage_idx(IDX_W'(g)),
			.in_vld(el_v[g]),
			.in_word(el_w[g]),
			.in_take(el_t[g]),
			.out_vld(el_v[g+1]),
			.out_word(el_w[g+1]),
			.out_take(el_t[g+1])
		);
	end

	assign take_o = !vo_q || ang_out.ready;
	assign el_t[NUM_CELLS] = take_o;
	assign el_full = round_sat(el_w[NUM_CELLS].ang, EL_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (take_o) begin
			vo_q <= el_v[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (take_o && el_v[NUM_CELLS]) begin
			az_q <= el_w[NUM_CELLS].az;
			el_q <= el_w[NUM_CELLS].el_zero ? '0 : el_full[EL_W-1:0];
		end
	end

	assign ang_out.valid = vo_q;
	assign ang_out.azimuth_deg = az_q;
	assign ang_out.elevation_deg = el_q;

	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> (az_q >= -17'sd46080) && (az_q <= 17'sd46080))
		else $error("azimuth word outside its saturation range");

	a_el_range: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> (el_q >= -16'sd23040) && (el_q <= 16'sd23040))
		else $error("elevation word outside its saturation range");

	a_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s0 |-> vec_in.ready)
		else $error("input stage empty but not ready");

	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_in.valid && vec_in.ready) |=> v_s0)
		else $error("accepted word did not reach the input stage");
endmodule
`default_nettype wire

### hw/rtl/vae_cordic_cell.sv
`default_nettype none
module vae_cordic_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [vae_pkg::IDX_W-1:0] stage_idx,
	input wire logic in_vld,
	input wire vae_pkg::vae_word_t in_word,
	output logic in_take,
	output logic out_vld,
	output vae_pkg::vae_word_t out_word,
	input wire logic out_take
);
	import vae_pkg::*;

	logic vld_q;
	vae_word_t word_q;
	vae_word_t word_d;
	logic signed [DP_W-1:0] xi;
	logic signed [DP_W-1:0] yi;
	logic signed [DP_W-1:0] dx;
	logic signed [DP_W-1:0] dy;
	logic signed [ANG_W-1:0] step;

	assign in_take = !vld_q || out_take;
	assign xi = in_word.x;
	assign yi = in_word.y;
	assign dx = yi >>> stage_idx;
	assign dy = xi >>> stage_idx;
	assign step = ATAN_DEG_Q16[stage_idx];

	always_comb begin
		word_d = in_word;
		if (!yi[DP_W-1]) begin
			word_d.x = xi + dx;
			word_d.y = yi - dy;
			word_d.ang = in_word.ang + step;
		end else begin
			word_d.x = xi - dx;
			word_d.y = yi + dy;
			word_d.ang = in_word.ang - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_take) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_vld) begin
			word_q <= word_d;
		end
	end

	assign out_vld = vld_q;
	assign out_word = word_q;
endmodule
`default_nettype wire

### hw/rtl/vae_gain_mult.sv
`default_nettype none
module vae_gain_mult (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [vae_pkg::THR_W-1:0] thr,
	input wire logic in_vld,
	input wire vae_pkg::vae_word_t in_word,
	output logic in_take,
	output logic out_vld,
	output vae_pkg::vae_word_t out_word,
	input wire logic out_take
);
	import vae_pkg::*;

	localparam int unsigned HALF = DP_W / 2;
	localparam int unsigned LO_P_W = HALF + 24;
	localparam int unsigned HI_P_W = HALF + 25;
	localparam int unsigned PROD_W = DP_W + 25;

	logic vld_s1;
	logic vld_s2;
	logic take_s1;
	logic take_s2;
	logic [LO_P_W-1:0] plo_s1;
	logic signed [HI_P_W-1:0] phi_s1;
	logic signed [IN_W-1:0] z_s1;
	logic signed [AZ_W-1:0] az_s1;
	logic z_small_s1;
	vae_word_t word_s2;
	logic [LO_P_W-1:0] plo_d;
	logic signed [HI_P_W-1:0] phi_d;
	logic signed [OUT_PRE_W-1:0] az_full;
	logic signed [PROD_W-1:0] prod;
	logic signed [DP_W-1:0] r;
	logic signed [DP_W-GUARD_BITS-1:0] rlsb;
	vae_word_t word_d;

	assign take_s2 = !vld_s2 || out_take;
	assign take_s1 = !vld_s1 || take_s2;
	assign in_take = take_s1;

	assign plo_d = LO_P_W'(in_word.x[HALF-1:0]) * LO_P_W'(INV_GAIN_Q24);
	assign phi_d = HI_P_W'($signed(in_word.x[DP_W-1:HALF]))
		* HI_P_W'($signed({1'b0, INV_GAIN_Q24}));
	assign az_full = round_sat(in_word.ang, AZ_LIMIT);

	assign prod = (PROD_W'(phi_s1) <<< HALF) + $signed(PROD_W'(plo_s1));
	assign r = prod[DP_W+23:24];
	assign rlsb = r[DP_W-1:GUARD_BITS];

	always_comb begin
		word_d.x = r;
		word_d.y = {{(DP_W-IN_W-GUARD_BITS){z_s1[IN_W-1]}}, z_s1, {GUARD_BITS{1'b0}}};
		word_d.ang = '0;
		word_d.z = z_s1;
		word_d.az = az_s1;
		word_d.az_zero = 1'b0;
		word_d.z_small = z_small_s1;
		word_d.el_zero = z_small_s1 && (rlsb < $signed((DP_W-GUARD_BITS)'(thr)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				vld_s1 <= in_vld;
			end
			if (take_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && in_vld) begin
			plo_s1 <= plo_d;
			phi_s1 <= phi_d;
			z_s1 <= in_word.z;
			z_small_s1 <= in_word.z_small;
			az_s1 <= in_word.az_zero ? '0 : az_full[AZ_W-1:0];
		end
		if (take_s2 && vld_s1) begin
			word_s2 <= word_d;
		end
	end

	assign out_vld = vld_s2;
	assign out_word = word_s2;
endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import vae_pkg::*;

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
	} vec_word_t;

	typedef struct packed {
		logic signed [AZ_W-1:0] az;
		logic signed [EL_W-1:0] el;
	} angle_word_t;

	localparam int NUM_STAGES = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int SCALE_SHIFT = 12;
	localparam longint GAIN_COMP = 64'sd10188014;
	localparam longint RIGHT_ANGLE = 64'sd5898240;
	localparam longint AZ_MAX = 64'sd46080;
	localparam longint EL_MAX = 64'sd23040;
	localparam longint ATAN_STEP [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};
	localparam int IN_MIN = -8388608;
	localparam int IN_MAX = 8388607;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	vae_in_if in_if ();
	vae_out_if out_if ();

	vector_azimuth_elevation_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.vec_in(in_if),
		.ang_out(out_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	vec_word_t pending_vecs [$];
	angle_word_t expected_angles [$];
	logic [THR_W-1:0] thr_model;
	int send_idle_pct;
	int recv_stall_pct;
	bit holdoff_go;
	bit long_hold;
	int error_count = 0;

	always #4 clk = ~clk;

	function automatic longint cordic_vectoring(input longint x0, input longint y0,
			input longint a0, output longint xf);
		longint x;
		longint y;
		longint a;
		longint dx;
		longint dy;
		x = x0;
		y = y0;
		a = a0;
		for (int i = 0; i < NUM_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				a = a + ATAN_STEP[i];
			end else begin
				x = x - dx;
				y = y + dy;
				a = a - ATAN_STEP[i];
			end
		end
		xf = x;
		return a;
	endfunction

	function automatic longint round_degrees(input longint acc, input longint lim);
		longint v;
		v = (acc + 128) >>> 8;
		if (v > lim) begin
			v = lim;
		end
		if (v < -lim) begin
			v = -lim;
		end
		return v;
	endfunction

	function automatic angle_word_t predict_angles(input vec_word_t w,
			input logic [THR_W-1:0] thr_bits);
		longint x;
		longint y;
		longint z;
		longint thr;
		longint cx;
		longint cy;
		longint tx;
		longint ang;
		longint xf;
		longint r;
		longint ef;
		longint az;
		longint el;
		angle_word_t res;
		x = longint'(w.x);
		y = longint'(w.y);
		z = longint'(w.z);
		thr = longint'(thr_bits);
		cx = x <<< SCALE_SHIFT;
		cy = y <<< SCALE_SHIFT;
		ang = 0;
		if (x < 0) begin
			tx = cx;
			if (y >= 0) begin
				cx = cy;
				cy = -tx;
				ang = RIGHT_ANGLE;
			end else begin
				cx = -cy;
				cy = tx;
				ang = -RIGHT_ANGLE;
			end
		end
		ang = cordic_vectoring(cx, cy, ang, xf);
		if ((x < 0 ? -x : x) < thr && (y < 0 ? -y : y) < thr) begin
			az = 0;
		end else begin
			az = round_degrees(ang, AZ_MAX);
		end
		r = (xf * GAIN_COMP) >>> 24;
		if ((z < 0 ? -z : z) < thr && (r >>> SCALE_SHIFT) < thr) begin
			el = 0;
		end else begin
			el = round_degrees(cordic_vectoring(r, z <<< SCALE_SHIFT, 0, ef), EL_MAX);
		end
		res.az = AZ_W'(az);
		res.el = EL_W'(el);
		return res;
	endfunction

	function automatic int pick_component(input int thr);
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($urandom_range(IN_MAX - IN_MIN)) + IN_MIN;
			4, 5: v = int'($urandom_range(4 * thr + 4)) - (2 * thr + 2);
			6: v = 0;
			7: begin
				case ($urandom_range(5))
					0: v = IN_MIN;
					1: v = IN_MAX;
					2: v = -1;
					3: v = 1;
					4: v = thr;
					default: v = -thr;
				endcase
			end
			default: v = (int'($urandom_range(65535)) - 32768) <<< $urandom_range(7);
		endcase
		return v;
	endfunction

	function automatic vec_word_t random_vec(input int thr);
		vec_word_t w;
		w.x = IN_W'(pick_component(thr));
		w.y = IN_W'(pick_component(thr));
		w.z = IN_W'(pick_component(thr));
		return w;
	endfunction

	function automatic vec_word_t make_vec(input int x, input int y, input int z);
		vec_word_t w;
		w.x = IN_W'(x);
		w.y = IN_W'(y);
		w.z = IN_W'(z);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_words
		vec_word_t next_vec;
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.vec_x <= '0;
			in_if.vec_y <= '0;
			in_if.vec_z <= '0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				next_vec.x = in_if.vec_x;
				next_vec.y = in_if.vec_y;
				next_vec.z = in_if.vec_z;
				expected_angles.push_back(predict_angles(next_vec, thr_model));
			end
			if (!in_if.valid || in_if.ready) begin
				if (pending_vecs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_vec = pending_vecs.pop_front();
					in_if.valid <= 1'b1;
					in_if.vec_x <= next_vec.x;
					in_if.vec_y <= next_vec.y;
					in_if.vec_z <= next_vec.z;
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_words
		angle_word_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_angles.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word az=%0d el=%0d", $time,
					out_if.azimuth_deg, out_if.elevation_deg);
			end else begin
				want = expected_angles.pop_front();
				if (out_if.azimuth_deg !== want.az) begin
					error_count++;
					$display("%0t: azimuth_deg expected %0d actual %0d", $time,
						want.az, out_if.azimuth_deg);
				end
				if (out_if.elevation_deg !== want.el) begin
					error_count++;
					$display("%0t: elevation_deg expected %0d actual %0d", $time,
						want.el, out_if.elevation_deg);
				end
			end
		end
	end

	// The receiver stops for a long stretch so that the pipeline fills and stalls its input.
	initial begin : receiver_holdoff
		long_hold = 1'b0;
		wait (holdoff_go);
		@(negedge clk);
		long_hold = 1'b1;
		repeat (300) @(negedge clk);
		long_hold = 1'b0;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_vecs.size() != 0 || in_if.valid || expected_angles.size() != 0);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] thr);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_model = thr;
	endtask

	task automatic run_phase(input logic [THR_W-1:0] thr, input int send_pct,
			input int recv_pct, input int count, input bit with_holdoff);
		write_threshold(thr);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (with_holdoff) begin
			holdoff_go = 1'b1;
		end
		pending_vecs.push_back(make_vec(0, 0, 0));
		pending_vecs.push_back(make_vec(int'(thr), 0, 0));
		pending_vecs.push_back(make_vec(0, -int'(thr), int'(thr) - 1));
		for (int i = 0; i < count; i++) begin
			pending_vecs.push_back(random_vec(int'(thr)));
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.vec_x = '0;
		in_if.vec_y = '0;
		in_if.vec_z = '0;
		out_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_go = 1'b0;
		thr_model = 10'd1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_vecs.push_back(make_vec(0, 0, 0));
		pending_vecs.push_back(make_vec(65536, 0, 0));
		pending_vecs.push_back(make_vec(-65536, 0, 0));
		pending_vecs.push_back(make_vec(-65536, -1, 0));
		pending_vecs.push_back(make_vec(-1, 0, 0));
		pending_vecs.push_back(make_vec(0, 65536, 0));
		pending_vecs.push_back(make_vec(0, -65536, 0));
		pending_vecs.push_back(make_vec(0, 0, IN_MAX));
		pending_vecs.push_back(make_vec(0, 0, IN_MIN));
		pending_vecs.push_back(make_vec(IN_MAX, IN_MAX, IN_MAX));
		pending_vecs.push_back(make_vec(IN_MIN, IN_MIN, IN_MIN));
		pending_vecs.push_back(make_vec(IN_MAX, IN_MIN, 0));
		pending_vecs.push_back(make_vec(IN_MIN, IN_MAX, IN_MIN));
		pending_vecs.push_back(make_vec(IN_MIN, 0, IN_MAX));
		pending_vecs.push_back(make_vec(1, 0, 0));
		pending_vecs.push_back(make_vec(0, 0, 1));
		pending_vecs.push_back(make_vec(0, 1, 0));
		pending_vecs.push_back(make_vec(-1, -1, -1));
		pending_vecs.push_back(make_vec(65536, 65536, 92682));
		pending_vecs.push_back(make_vec(-65536, 65536, -92682));
		pending_vecs.push_back(make_vec(IN_MIN, -1, 1));
		wait_drained();

		run_phase(10'd0, 0, 0, 240, 1'b1);
		run_phase(10'd1023, 82, 0, 240, 1'b0);
		run_phase(THR_W'($urandom_range(1, 1022)), 0, 82, 240, 1'b0);
		run_phase(THR_W'($urandom_range(1023)), 7, 7, 240, 1'b0);
		run_phase(10'd1, 0, 0, 240, 1'b0);

		repeat (40) @(posedge clk);
		if (expected_angles.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected words never arrived", $time, expected_angles.size());
		end
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/vae_pkg.sv
hw/rtl/vae_in_if.sv
hw/rtl/vae_out_if.sv
hw/rtl/vae_cordic_cell.sv
hw/rtl/vae_gain_mult.sv
hw/rtl/vector_azimuth_elevation_top.sv
verif/testbench.sv
